@@ hw/rtl/lcrf_pkg.sv @@
// ----------------------------------------------------------------------------
// lcrf_pkg: shared definitions for the covered range filter
// Field widths, command codes, stream packing and the table depth default.
// ----------------------------------------------------------------------------
package lcrf_pkg;

  // default number of table entries
  localparam int unsigned DefEntries = 64;

  // payload field widths
  localparam int unsigned StartW = 64;
  localparam int unsigned LenW   = 17;
  localparam int unsigned KeyW   = StartW + LenW;

  // largest length kept, longer requests saturate here
  localparam logic [LenW-1:0] LenMax = 17'd65536;

  // stream widths, padded to whole bytes
  localparam int unsigned STdataW = ((StartW + LenW + 7) / 8) * 8;
  localparam int unsigned MTdataW = 8;

  // result bit positions in the output tdata
  localparam int unsigned BitCovered = 0;
  localparam int unsigned BitHit     = 1;
  localparam int unsigned BitEvicted = 2;

  // command codes carried on the input tuser
  localparam logic CmdEnter = 1'b0;
  localparam logic CmdClear = 1'b1;

endpackage

@@ hw/rtl/lcrf_ram.sv @@
// ----------------------------------------------------------------------------
// lcrf_ram: simple dual port synchronous memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lcrf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/lru_covered_range_filter_core.sv @@
// ----------------------------------------------------------------------------
// lru_covered_range_filter_core: LRU history of logged ranges
// Fully associative table of (start, length) entries kept in recency order.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tuser is the command (enter or clear), tdata
//   holds range_start and range_length. m_axis returns one result per
//   request with the covered, hit and evicted flags in tdata.
//   A request walks the key memory one entry a cycle until its offset is
//   found or all filled entries have been read; a hit or an eviction then
//   sweeps the rank memory to re-rank every filled entry, one entry a cycle.
//   The next request is taken in the cycle after the result is loaded. The
//   sweeps go through the single read port of each memory. One request is
//   worked on at a time; s_axis_tready_o is high while idle. The result sits
//   in an output register, so the next request is taken while a result
//   waits; a stalled receiver holds only the final step. Reset empties the
//   table (fill count zero); memory contents are left as they are and never
//   read before they are written.
// ----------------------------------------------------------------------------
module lru_covered_range_filter_core #(
  parameter int unsigned ENTRIES = lcrf_pkg::DefEntries
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // requests: tdata = range_start, range_length; tuser = cmd
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [lcrf_pkg::STdataW-1:0] s_axis_tdata_i,
  input  logic                        s_axis_tuser_i,
  // results: tdata = covered, hit, evicted
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [lcrf_pkg::MTdataW-1:0] m_axis_tdata_o
);

  localparam int unsigned IdxW  = $clog2(ENTRIES);
  localparam int unsigned CntW  = $clog2(ENTRIES + 1);
  localparam int unsigned StartW = lcrf_pkg::StartW;
  localparam int unsigned LenW   = lcrf_pkg::LenW;
  localparam int unsigned KeyW   = lcrf_pkg::KeyW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_WRITE,
    ST_RESP
  } state_e;

  state_e state_q, state_d;

  logic [StartW-1:0] req_start_q, req_start_d;
  logic [LenW-1:0]   req_len_q, req_len_d;
  logic [LenW-1:0]   wlen_q, wlen_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic [CntW-1:0]   issue_q, issue_d;
  logic              pend_q, pend_d;
  logic [IdxW-1:0]   pend_idx_q, pend_idx_d;
  logic [IdxW-1:0]   slot_q, slot_d;
  logic [IdxW-1:0]   victim_q, victim_d;
  logic [IdxW-1:0]   thr_q, thr_d;
  logic [IdxW-1:0]   new_rank_q, new_rank_d;
  logic              covered_q, covered_d;
  logic              hit_q, hit_d;
  logic              evicted_q, evicted_d;
  logic              m_valid_q, m_valid_d;
  logic [lcrf_pkg::MTdataW-1:0] m_data_q, m_data_d;

  logic              key_we;
  logic [KeyW-1:0]   key_rdata;
  logic              rank_we;
  logic [IdxW-1:0]   rank_waddr;
  logic [IdxW-1:0]   rank_wdata;
  logic [IdxW-1:0]   rank_rdata;
  logic [IdxW-1:0]   rd_addr;

  logic [StartW-1:0] in_start;
  logic [LenW-1:0]   in_len;
  logic [LenW-1:0]   in_len_sat;
  logic [StartW-1:0] rd_start;
  logic [LenW-1:0]   rd_len;

  // request fields and saturation
  assign in_start   = s_axis_tdata_i[StartW-1:0];
  assign in_len     = s_axis_tdata_i[KeyW-1:StartW];
  assign in_len_sat = (in_len > lcrf_pkg::LenMax) ? lcrf_pkg::LenMax : in_len;

  assign rd_start = key_rdata[StartW-1:0];
  assign rd_len   = key_rdata[KeyW-1:StartW];
  assign rd_addr  = issue_q[IdxW-1:0];

  // key memory: start offset and length per slot
  lcrf_ram #(
    .Width(KeyW),
    .Depth(ENTRIES)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(slot_q),
    .wdata_i({wlen_q, req_start_q}),
    .raddr_i(rd_addr),
    .rdata_o(key_rdata)
  );

  // rank memory: recency rank per slot, 0 = least recent
  lcrf_ram #(
    .Width(IdxW),
    .Depth(ENTRIES)
  ) u_rank_ram (
    .clk_i  (clk_i),
    .we_i   (rank_we),
    .waddr_i(rank_waddr),
    .wdata_i(rank_wdata),
    .raddr_i(rd_addr),
    .rdata_o(rank_rdata)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    req_start_d = req_start_q;
    req_len_d   = req_len_q;
    wlen_d      = wlen_q;
    fill_d      = fill_q;
    issue_d     = issue_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    slot_d      = slot_q;
    victim_d    = victim_q;
    thr_d       = thr_q;
    new_rank_d  = new_rank_q;
    covered_d   = covered_q;
    hit_d       = hit_q;
    evicted_d   = evicted_q;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;
    key_we      = 1'b0;
    rank_we     = 1'b0;
    rank_waddr  = pend_idx_q;
    rank_wdata  = rank_rdata;

    // result taken by the receiver
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          covered_d = 1'b0;
          hit_d     = 1'b0;
          evicted_d = 1'b0;
          issue_d   = '0;
          pend_d    = 1'b0;
          if (s_axis_tuser_i == lcrf_pkg::CmdClear) begin
            fill_d  = '0;
            state_d = ST_RESP;
          end else begin
            req_start_d = in_start;
            req_len_d   = in_len_sat;
            state_d     = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (pend_q && (rd_start == req_start_q)) begin
          // offset found: re-rank around its old rank
          hit_d      = 1'b1;
          slot_d     = pend_idx_q;
          thr_d      = rank_rdata;
          new_rank_d = IdxW'(fill_q - CntW'(1));
          covered_d  = (req_len_q <= rd_len);
          wlen_d     = (req_len_q <= rd_len) ? rd_len : req_len_q;
          issue_d    = '0;
          pend_d     = 1'b0;
          state_d    = ST_UPDATE;
        end else begin
          // remember the least recent slot as eviction candidate
          if (pend_q && (rank_rdata == '0)) begin
            victim_d = pend_idx_q;
          end
          if (issue_q < fill_q) begin
            issue_d    = CntW'(issue_q + CntW'(1));
            pend_d     = 1'b1;
            pend_idx_d = issue_q[IdxW-1:0];
          end else begin
            pend_d = 1'b0;
            if (!pend_q) begin
              wlen_d = req_len_q;
              if (fill_q < CntW'(ENTRIES)) begin
                // free slot at the end of the filled region
                slot_d     = fill_q[IdxW-1:0];
                new_rank_d = fill_q[IdxW-1:0];
                state_d    = ST_WRITE;
              end else begin
                // full table: replace the least recent entry
                slot_d     = victim_q;
                thr_d      = '0;
                new_rank_d = IdxW'(fill_q - CntW'(1));
                evicted_d  = 1'b1;
                issue_d    = '0;
                state_d    = ST_UPDATE;
              end
            end
          end
        end
      end

      ST_UPDATE: begin
        // read-modify-write sweep over the ranks of the filled slots
        if (pend_q) begin
          rank_we    = 1'b1;
          rank_waddr = pend_idx_q;
          if (pend_idx_q == slot_q) begin
            rank_wdata = new_rank_q;
          end else if (rank_rdata > thr_q) begin
            rank_wdata = rank_rdata - IdxW'(1);
          end else begin
            rank_wdata = rank_rdata;
          end
        end
        if (issue_q < fill_q) begin
          issue_d    = CntW'(issue_q + CntW'(1));
          pend_d     = 1'b1;
          pend_idx_d = issue_q[IdxW-1:0];
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = ST_WRITE;
          end
        end
      end

      ST_WRITE: begin
        // store key and length unless the range was already covered
        key_we = !covered_q;
        if (!hit_q && !evicted_q) begin
          rank_we    = 1'b1;
          rank_waddr = slot_q;
          rank_wdata = new_rank_q;
          fill_d     = CntW'(fill_q + CntW'(1));
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_data_d                       = '0;
          m_data_d[lcrf_pkg::BitCovered] = covered_q;
          m_data_d[lcrf_pkg::BitHit]     = hit_q;
          m_data_d[lcrf_pkg::BitEvicted] = evicted_q;
          m_valid_d                      = 1'b1;
          state_d                        = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      issue_q   <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      issue_q   <= issue_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_start_q <= req_start_d;
    req_len_q   <= req_len_d;
    wlen_q      <= wlen_d;
    pend_idx_q  <= pend_idx_d;
    slot_q      <= slot_d;
    victim_q    <= victim_d;
    thr_q       <= thr_d;
    new_rank_q  <= new_rank_d;
    covered_q   <= covered_d;
    hit_q       <= hit_d;
    evicted_q   <= evicted_d;
    m_data_q    <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

@@ tb/lru_covered_range_filter_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_covered_range_filter_core_test: self-checking bench for the range filter
// Drives enter and clear requests through the request stream. A directed
// table comes first, then random traffic over key pools of several sizes so
// that the table fills, hits and evicts. Every request is run through a
// local LRU table model. Each result is checked field by field, in order.
// ----------------------------------------------------------------------------
module lru_covered_range_filter_core_test;

  localparam int unsigned TableDepth = lcrf_pkg::DefEntries;
  localparam int unsigned PadW       = lcrf_pkg::STdataW - lcrf_pkg::KeyW;
  localparam int unsigned PoolSize   = 160;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic covered;
    logic hit;
    logic evicted;
  } range_result_t;

  typedef struct packed {
    logic          cmd;
    logic [63:0]   start;
    logic [16:0]   len;
    bit            typed;
    range_result_t res;
  } filter_row_t;

  // block ports
  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         s_axis_tvalid_i = 1'b0;
  logic                         s_axis_tready_o;
  // range_start, range_length, padding
  logic [lcrf_pkg::STdataW-1:0] s_axis_tdata_i  = '0;
  logic                         s_axis_tuser_i  = 1'b0;  // cmd
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i = 1'b0;
  // covered, hit, evicted, padding
  logic [lcrf_pkg::MTdataW-1:0] m_axis_tdata_o;

  // model of the history table
  logic [63:0]  hist_start [TableDepth];
  logic [16:0]  hist_len   [TableDepth];
  int unsigned  hist_rank  [TableDepth];
  int unsigned  hist_fill  = 0;

  range_result_t pending_results [$];
  logic [63:0]   key_pool [PoolSize];
  int unsigned   fail_count  = 0;
  bit            steady_flow = 1'b0;

  // directed requests, typed result where it is obvious
  filter_row_t directed_rows [19] = '{
    '{lcrf_pkg::CmdEnter, 64'h0,                  17'd0,     1'b1, 3'b000},
    '{lcrf_pkg::CmdEnter, 64'h0,                  17'd0,     1'b1, 3'b110},
    '{lcrf_pkg::CmdEnter, 64'h0,                  17'h1FFFF, 1'b1, 3'b010},
    '{lcrf_pkg::CmdEnter, 64'h0,             lcrf_pkg::LenMax, 1'b1, 3'b110},
    '{lcrf_pkg::CmdEnter, 64'hFFFF_FFFF_FFFF_FFFF, lcrf_pkg::LenMax, 1'b1, 3'b000},
    '{lcrf_pkg::CmdEnter, 64'hFFFF_FFFF_FFFF_FFFF, 17'd65537, 1'b1, 3'b110},
    '{lcrf_pkg::CmdEnter, 64'h5555_5555_5555_5555, 17'h0AAAA, 1'b1, 3'b000},
    '{lcrf_pkg::CmdEnter, 64'h5555_5555_5555_5555, 17'h15555, 1'b1, 3'b010},
    '{lcrf_pkg::CmdEnter, 64'hAAAA_AAAA_AAAA_AAAA, 17'h15555, 1'b1, 3'b000},
    '{lcrf_pkg::CmdEnter, 64'h5555_5555_5555_5555, 17'h0AAAA, 1'b0, 3'b000},
    '{lcrf_pkg::CmdEnter, 64'h8000_0000_0000_0000, 17'd1,     1'b0, 3'b000},
    '{lcrf_pkg::CmdEnter, 64'h0000_0000_0000_0001, 17'd1,     1'b0, 3'b000},
    '{lcrf_pkg::CmdEnter, 64'h8000_0000_0000_0000, 17'd2,     1'b0, 3'b000},
    '{lcrf_pkg::CmdClear, 64'hFFFF_FFFF_FFFF_FFFF, 17'h1FFFF, 1'b1, 3'b000},
    '{lcrf_pkg::CmdEnter, 64'hFFFF_FFFF_FFFF_FFFF, 17'd0,     1'b1, 3'b000},
    '{lcrf_pkg::CmdEnter, 64'h0,                  17'd1,     1'b1, 3'b000},
    '{lcrf_pkg::CmdClear, 64'h0,                  17'd0,     1'b1, 3'b000},
    '{lcrf_pkg::CmdClear, 64'h0,                  17'd0,     1'b1, 3'b000},
    '{lcrf_pkg::CmdEnter, 64'h0000_0000_0000_0001, 17'd0,     1'b1, 3'b000}
  };

  lru_covered_range_filter_core #(
    .ENTRIES(TableDepth)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // lookup, re-rank and fill or evict, as the table does it
  function automatic range_result_t predict_range_lookup(input logic cmd,
                                                         input logic [63:0] start,
                                                         input logic [16:0] len);
    range_result_t res;
    logic [16:0]   eff_len;
    bit            found;
    bit            picked;
    int unsigned   slot;
    int unsigned   old_rank;
    res     = '0;
    found   = 1'b0;
    picked  = 1'b0;
    slot    = 0;
    if (cmd == lcrf_pkg::CmdClear) begin
      hist_fill = 0;
      return res;
    end
    eff_len = (len > lcrf_pkg::LenMax) ? lcrf_pkg::LenMax : len;
    for (int i = 0; i < hist_fill; i++) begin
      if (!found && hist_start[i] == start) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      old_rank = hist_rank[slot];
      for (int i = 0; i < hist_fill; i++) begin
        if (hist_rank[i] > old_rank) hist_rank[i]--;
      end
      hist_rank[slot] = hist_fill - 1;
      res.hit = 1'b1;
      if (eff_len <= hist_len[slot]) res.covered = 1'b1;
      else hist_len[slot] = eff_len;
      return res;
    end
    if (hist_fill < TableDepth) begin
      slot = hist_fill;
      hist_fill++;
    end else begin
      // replace the least recent entry, everyone else moves down one rank
      for (int i = 0; i < TableDepth; i++) begin
        if (!picked && hist_rank[i] == 0) begin
          slot   = i;
          picked = 1'b1;
        end
      end
      for (int i = 0; i < hist_fill; i++) begin
        if (hist_rank[i] > 0) hist_rank[i]--;
      end
      res.evicted = 1'b1;
    end
    hist_start[slot] = start;
    hist_len[slot]   = eff_len;
    hist_rank[slot]  = hist_fill - 1;
    return res;
  endfunction

  // length mix: zero, maximum, saturating and anything in range
  function automatic logic [16:0] pick_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 17'd0;
    if (roll < 20) return lcrf_pkg::LenMax;
    if (roll < 30) return 17'($urandom_range(65537, 131071));
    return 17'($urandom_range(0, 65536));
  endfunction

  // present one request, wait for the handshake, log its expected result
  task automatic send_request(input logic cmd, input logic [63:0] start,
                              input logic [16:0] len, input bit typed,
                              input range_result_t typed_res);
    range_result_t res;
    if (!steady_flow && $urandom_range(0, 99) < 25) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {{PadW{1'b0}}, len, start};
    do @(posedge clk_i); while (!s_axis_tready_o);
    res = predict_range_lookup(cmd, start, len);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // hold off requests until every result is back
  task automatic wait_until_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready_i <= steady_flow || ($urandom_range(0, 99) >= 25);
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    range_result_t want;
    range_result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.covered = m_axis_tdata_o[lcrf_pkg::BitCovered];
      got.hit     = m_axis_tdata_o[lcrf_pkg::BitHit];
      got.evicted = m_axis_tdata_o[lcrf_pkg::BitEvicted];
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("unexpected result: covered=%0b hit=%0b evicted=%0b",
                   got.covered, got.hit, got.evicted);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("result mismatch: expected covered=%0b hit=%0b evicted=%0b, got %0b %0b %0b",
                     want.covered, want.hit, want.evicted,
                     got.covered, got.hit, got.evicted);
        end
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned pool_span;
    int unsigned roll;
    logic [63:0] key;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].cmd, directed_rows[i].start, directed_rows[i].len,
                   directed_rows[i].typed, directed_rows[i].res);
    end
    wait_until_drained();

    // fill the table past its depth so the oldest entries get evicted
    send_request(lcrf_pkg::CmdClear, {$urandom, $urandom}, 17'($urandom), 1'b0, '0);
    for (int n = 0; n < TableDepth + 4; n++) begin
      send_request(lcrf_pkg::CmdEnter, key_pool[n], pick_length(), 1'b0, '0);
    end
    wait_until_drained();

    // random traffic, pool size sets the hit rate
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: pool_span = 40;
        1: pool_span = 72;
        2: pool_span = 96;
        default: pool_span = PoolSize;
      endcase
      steady_flow = (p == 1);
      for (int n = 0; n < 330; n++) begin
        roll = $urandom_range(0, 99);
        if (roll == 0) begin
          send_request(lcrf_pkg::CmdClear, {$urandom, $urandom}, 17'($urandom), 1'b0, '0);
        end else begin
          if (roll < 11) key = {$urandom, $urandom};
          else key = key_pool[$urandom_range(0, pool_span - 1)];
          send_request(lcrf_pkg::CmdEnter, key, pick_length(), 1'b0, '0);
        end
      end
      steady_flow = 1'b0;
      wait_until_drained();
    end

    // let any stray result show up
    repeat (2 * TableDepth + 16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
